// File: rtl/core/vslru_pkg.sv
`default_nettype none

package vslru_pkg;

    // Widths of the item fields
    localparam int SEL_W         = 7;
    localparam int SLOT_OUT_W    = 2;
    localparam int SELECTOR_BITS = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PINS_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SELECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SLOT  = 2'd2;

    localparam int DEF_NUM_SLOTS = 4;

    // Selector masks, limited to the supported selector width
    localparam logic [SEL_W-1:0] SEL_LIMIT   = SEL_W'((1 << SELECTOR_BITS) - 1);
    localparam logic [SEL_W-1:0] MASK_NARROW = 7'h3F;
    localparam logic [SEL_W-1:0] MASK_WIDE   = 7'h7F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic pins_enabled;
        logic match;
        logic last;
    } status_t;

    function automatic logic [SEL_W-1:0] sel_mask(input logic wide);
        logic [SEL_W-1:0] m;
        m = wide ? MASK_WIDE : MASK_NARROW;
        return m & SEL_LIMIT;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/vslru_ifs.sv
`default_nettype none

interface vslru_req_if;
    logic                           valid;
    logic                           ready;
    logic [vslru_pkg::SEL_W-1:0]    requested_selector;

    modport source (output valid, output requested_selector, input ready);
    modport sink   (input valid, input requested_selector, output ready);
endinterface

interface vslru_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [vslru_pkg::SLOT_OUT_W-1:0]   target_slot;
    logic                               needs_write;
    logic [vslru_pkg::SEL_W-1:0]        write_value;
    logic                               drive_pins;

    modport source (output valid, output target_slot, output needs_write,
                    output write_value, output drive_pins, input ready);
    modport sink   (input valid, input target_slot, input needs_write,
                    input write_value, input drive_pins, output ready);
endinterface

interface vslru_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [vslru_pkg::CFG_IDX_W-1:0]    index;
    logic [vslru_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/voltage_slot_lru_select.sv
`default_nettype none

// Voltage-set slot selector with least-recently-used replacement. Each
// request item gives one result item. With pins enabled the slots are probed
// one per cycle in recency order: the selector is latched on acceptance, the
// search probes slots until a match or the last slot, and an update step
// follows; with pins disabled the search is skipped. The result is held
// until taken, and the next item is accepted in the cycle after that. The
// configuration channel is always ready; writing the initial slot restarts
// the recency order and forgets every stored selector. Configure only while
// no item is in flight.
module voltage_slot_lru_select
#(
    parameter int NUM_SLOTS = vslru_pkg::DEF_NUM_SLOTS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    vslru_req_if.sink       req,
    vslru_rsp_if.source     rsp,
    vslru_cfg_if.sink       cfg
);

    vslru_pkg::cmd_t    cmd;
    vslru_pkg::status_t status;
    logic               req_ready;
    logic               rsp_valid;

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign cfg.ready = 1'b1;

    vslru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    vslru_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .requested_selector (req.requested_selector),
        .cfg_wr             (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .target_slot        (rsp.target_slot),
        .needs_write        (rsp.needs_write),
        .write_value        (rsp.write_value),
        .drive_pins         (rsp.drive_pins)
    );

    // one item in flight: never ready while a result is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready) |=> !req_ready)
        else $error("still ready after accepting an item");

    // a hit only exists with the LRU search on
    a_hit_needs_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.needs_write) |-> rsp.drive_pins)
        else $error("hit reported with pins disabled");

    a_update_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.update))
        else $error("result offered without an update cycle");

endmodule

`default_nettype wire

// File: rtl/core/vslru_ctrl.sv
`default_nettype none

module vslru_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output vslru_pkg::cmd_t         cmd,
    input  wire vslru_pkg::status_t status
);

    vslru_pkg::state_t state_reg;
    vslru_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vslru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vslru_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    // without pins the current slot is rewritten, no search
                    state_next = status.pins_enabled ? vslru_pkg::ST_SEARCH
                                                     : vslru_pkg::ST_UPDATE;
                end
            end
            vslru_pkg::ST_SEARCH:
            begin
                if (status.match || status.last)
                begin
                    state_next = vslru_pkg::ST_UPDATE;
                end
            end
            vslru_pkg::ST_UPDATE:
            begin
                state_next = vslru_pkg::ST_RESULT;
            end
            vslru_pkg::ST_RESULT:
            begin
                if (rsp_ready)
                begin
                    state_next = vslru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vslru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            vslru_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            vslru_pkg::ST_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            vslru_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            vslru_pkg::ST_RESULT:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/vslru_dpath.sv
`default_nettype none

module vslru_dpath
#(
    parameter int NUM_SLOTS = vslru_pkg::DEF_NUM_SLOTS
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire vslru_pkg::cmd_t                    cmd,
    output vslru_pkg::status_t                      status,
    input  wire logic [vslru_pkg::SEL_W-1:0]        requested_selector,
    input  wire logic                               cfg_wr,
    input  wire logic [vslru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vslru_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [vslru_pkg::SLOT_OUT_W-1:0]        target_slot,
    output logic                                    needs_write,
    output logic [vslru_pkg::SEL_W-1:0]             write_value,
    output logic                                    drive_pins
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_POS = SW'(NUM_SLOTS - 1);

    logic                           pins_en_reg;
    logic                           wide_reg;
    logic [SW-1:0]                  order_reg   [NUM_SLOTS];
    logic [vslru_pkg::SEL_W-1:0]    slot_sel_reg[NUM_SLOTS];
    logic [NUM_SLOTS-1:0]           valid_reg;
    logic [SW-1:0]                  current_reg;
    logic [vslru_pkg::SEL_W-1:0]    sel_reg;
    logic [SW-1:0]                  pos_reg;
    logic                           hit_reg;
    logic [SW-1:0]                  tgt_reg;
    logic                           nw_reg;
    logic                           drive_reg;

    logic [SW-1:0]                  probe_slot;
    logic [SW-1:0]                  target;
    logic [SW-1:0]                  first_slot;
    logic [1:0]                     init_raw;
    logic                           restart;

    assign probe_slot = order_reg[pos_reg];
    assign target     = pins_en_reg ? probe_slot : current_reg;

    assign status.pins_enabled = pins_en_reg;
    assign status.match        = valid_reg[probe_slot] && (slot_sel_reg[probe_slot] == sel_reg);
    assign status.last         = (pos_reg == LAST_POS);

    // Saturate the initial slot to the last slot
    assign init_raw   = cfg_data[1:0];
    assign first_slot = (32'(init_raw) >= NUM_SLOTS) ? LAST_POS : SW'(init_raw);
    assign restart    = cfg_wr && (cfg_index == vslru_pkg::CFG_INITIAL_SLOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_en_reg <= 1'b0;
            wide_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                vslru_pkg::CFG_PINS_ENABLED:  pins_en_reg <= cfg_data[0];
                vslru_pkg::CFG_WIDE_SELECTOR: wide_reg    <= cfg_data[0];
                default:                      pins_en_reg <= pins_en_reg;
            endcase
        end
    end

    // Recency order, valid bits and current slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                order_reg[i] <= SW'(i);
            end
            valid_reg   <= '0;
            current_reg <= '0;
        end
        else if (restart)
        begin
            // identity order with the initial slot swapped to the front
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (i == 0)
                begin
                    order_reg[i] <= first_slot;
                end
                else if (SW'(i) == first_slot)
                begin
                    order_reg[i] <= '0;
                end
                else
                begin
                    order_reg[i] <= SW'(i);
                end
            end
            valid_reg    <= '0;
            current_reg  <= first_slot;
        end
        else if (cmd.update)
        begin
            if (pins_en_reg)
            begin
                for (int i = 1; i < NUM_SLOTS; i++)
                begin
                    if (SW'(i) <= pos_reg)
                    begin
                        order_reg[i] <= order_reg[i-1];
                    end
                end
                order_reg[0] <= target;
            end
            if (!hit_reg)
            begin
                current_reg       <= target;
                valid_reg[target] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && !hit_reg)
        begin
            slot_sel_reg[target] <= sel_reg;
        end
    end

    // Search walk and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            pos_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (status.match)
            begin
                hit_reg <= 1'b1;
            end
            else if (!status.last)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sel_reg   <= requested_selector & vslru_pkg::sel_mask(wide_reg);
            drive_reg <= pins_en_reg;
        end
        if (cmd.update)
        begin
            tgt_reg <= target;
            nw_reg  <= !hit_reg;
        end
    end

    assign target_slot = vslru_pkg::SLOT_OUT_W'(tgt_reg);
    assign needs_write = nw_reg;
    assign write_value = sel_reg;
    assign drive_pins  = drive_reg;

endmodule

`default_nettype wire

// File: test/voltage_slot_lru_select_tb.sv
`timescale 1ns / 100ps

module voltage_slot_lru_select_tb;

    localparam int SEL_W      = vslru_pkg::SEL_W;
    localparam int SLOT_OUT_W = vslru_pkg::SLOT_OUT_W;
    localparam int CFG_IDX_W  = vslru_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = vslru_pkg::CFG_DATA_W;

    localparam int NSLOT         = vslru_pkg::DEF_NUM_SLOTS;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 80;
    localparam int POOL_SIZE     = 6;

    localparam logic [SEL_W-1:0]     NARROW_SEL     = 7'h3F;
    localparam logic [SEL_W-1:0]     WIDE_SEL       = 7'h7F;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  rewrite;
        logic [SEL_W-1:0]      sel_value;
        logic                  pins;
    } slot_choice_t;

    // Tracks slot contents and recency, and queues the slot choice per request
    class slot_scoreboard;
        bit                    pins_on;
        bit                    wide_on;
        logic [1:0]            first_slot;
        logic [SLOT_OUT_W-1:0] order [NSLOT];
        logic [SEL_W-1:0]      stored [NSLOT];
        bit                    filled [NSLOT];
        logic [SLOT_OUT_W-1:0] cur;
        slot_choice_t          due [$];
        int                    errors;
        int                    requests;
        int                    hits;
        int                    rewrites;

        function new();
            pins_on    = 1'b0;
            wide_on    = 1'b0;
            first_slot = '0;
            errors     = 0;
            requests   = 0;
            hits       = 0;
            rewrites   = 0;
            restart();
        endfunction

        function void restart();
            logic [SLOT_OUT_W-1:0] first;
            first = (int'(first_slot) >= NSLOT) ? SLOT_OUT_W'(NSLOT - 1) : first_slot;
            for (int i = 0; i < NSLOT; i++)
            begin
                order[i]  = SLOT_OUT_W'(i);
                stored[i] = '0;
                filled[i] = 1'b0;
            end
            order[first] = '0;
            order[0]     = first;
            cur          = first;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                vslru_pkg::CFG_PINS_ENABLED:  pins_on = data[0];
                vslru_pkg::CFG_WIDE_SELECTOR: wide_on = data[0];
                vslru_pkg::CFG_INITIAL_SLOT:
                begin
                    first_slot = data[1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void note_request(logic [SEL_W-1:0] raw);
            logic [SEL_W-1:0]      sel;
            logic [SLOT_OUT_W-1:0] tgt;
            int                    pos;
            bit                    hit;
            slot_choice_t          choice;
            sel = raw & (wide_on ? WIDE_SEL : NARROW_SEL);
            pos = NSLOT - 1;
            hit = 1'b0;
            if (pins_on)
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!hit && filled[order[i]] && stored[order[i]] == sel)
                    begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                tgt = order[pos];
                for (int i = pos; i > 0; i--)
                    order[i] = order[i - 1];
                order[0] = tgt;
            end
            else
                tgt = cur;
            // a hit leaves current slot alone
            if (!hit)
            begin
                cur         = tgt;
                stored[tgt] = sel;
                filled[tgt] = 1'b1;
            end
            choice.slot      = tgt;
            choice.rewrite   = !hit;
            choice.sel_value = sel;
            choice.pins      = pins_on;
            due.push_back(choice);
            requests++;
            if (hit)
                hits++;
            else
                rewrites++;
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(slot_choice_t got);
            slot_choice_t want;
            if (due.size() == 0)
            begin
                report("result with no request pending", got.slot, 0);
            end
            else
            begin
                want = due.pop_front();
                if (got.slot !== want.slot)
                    report("target_slot", got.slot, want.slot);
                if (got.rewrite !== want.rewrite)
                    report("needs_write", got.rewrite, want.rewrite);
                if (got.sel_value !== want.sel_value)
                    report("write_value", got.sel_value, want.sel_value);
                if (got.pins !== want.pins)
                    report("drive_pins", got.pins, want.pins);
            end
        endtask

        function int pending();
            return due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vslru_req_if req_ch ();
    vslru_rsp_if rsp_ch ();
    vslru_cfg_if cfg_ch ();

    voltage_slot_lru_select u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    slot_scoreboard   sb;
    bit               rx_stall_req = 1'b0;
    logic [SEL_W-1:0] sel_pool [POOL_SIZE];
    int               settings_run = 0;
    slot_choice_t     rsp_seen;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen.slot      = rsp_ch.target_slot;
                rsp_seen.rewrite   = rsp_ch.needs_write;
                rsp_seen.sel_value = rsp_ch.write_value;
                rsp_seen.pins      = rsp_ch.drive_pins;
                sb.check_result(rsp_seen);
            end
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.requested_selector);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // Receiver: stall pattern is re-drawn at random; long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       tick;
        mode = RX_OPEN;
        tick = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (rx_stall_req)
            begin
                rx_stall_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
            begin
                if (tick % 32 == 0)
                    mode = rx_mode_t'($urandom_range(0, 3));
                case (mode)
                    RX_OPEN:    rsp_ch.ready <= 1'b1;
                    RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: rsp_ch.ready <= ((tick % 8) < 5);
                    default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_request(logic [SEL_W-1:0] sel);
        req_ch.valid              <= 1'b1;
        req_ch.requested_selector <= sel;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_batch(int vals[$]);
        foreach (vals[i])
            send_request(SEL_W'(vals[i]));
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Upper data bits are junk; the block must ignore them
    task automatic configure(bit pins, bit wide, logic [1:0] init, bit set_init);
        logic [CFG_DATA_W-1:0] d;
        wait_idle();
        d    = CFG_DATA_W'($urandom);
        d[0] = pins;
        write_reg(vslru_pkg::CFG_PINS_ENABLED, d);
        d    = CFG_DATA_W'($urandom);
        d[0] = wide;
        write_reg(vslru_pkg::CFG_WIDE_SELECTOR, d);
        if (set_init)
        begin
            d      = CFG_DATA_W'($urandom);
            d[1:0] = init;
            write_reg(vslru_pkg::CFG_INITIAL_SLOT, d);
        end
        settings_run++;
    endtask

    function automatic logic [SEL_W-1:0] pick_selector();
        if ($urandom_range(0, 3) != 0)
            return sel_pool[$urandom_range(0, POOL_SIZE - 1)];
        return SEL_W'($urandom_range(0, 127));
    endfunction

    task automatic run_requests(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            while (burst > 0 && left > 0)
            begin
                send_request(pick_selector());
                burst--;
                left--;
            end
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        int batch[$];
        // reset settings: pins off, 6-bit selector
        batch = '{0, 127, 64, 63};
        send_batch(batch);
        configure(1'b1, 1'b1, 2'd3, 1'b1);
        write_reg(CFG_UNUSED_IDX, 8'hFF);
        // unwritten slots must not match zero; then fill, hit deep, evict
        batch = '{0, 0, 127, 1, 2, 0, 5, 127};
        send_batch(batch);
        configure(1'b1, 1'b0, 2'd0, 1'b0);
        batch = '{127, 63, 64};
        send_batch(batch);
        configure(1'b0, 1'b0, 2'd1, 1'b1);
        batch = '{9, 9};
        send_batch(batch);
        configure(1'b1, 1'b1, 2'd0, 1'b0);
        batch = '{9, 10, 9};
        send_batch(batch);
        // after a hit, pins off must reuse the slot of the last miss
        configure(1'b0, 1'b1, 2'd0, 1'b0);
        batch = '{20};
        send_batch(batch);
    endtask

    task automatic run_random_phase(int ph);
        bit         pins;
        bit         wide;
        logic [1:0] init;
        bit         set_init;
        case (ph)
            0:
            begin
                pins = 1'b1; wide = 1'b1; init = 2'd0; set_init = 1'b1;
            end
            1:
            begin
                pins = 1'b1; wide = 1'b0; init = 2'd3; set_init = 1'b1;
            end
            2:
            begin
                pins = 1'b0; wide = 1'b1; init = 2'd2; set_init = 1'b1;
            end
            default:
            begin
                pins     = ($urandom_range(0, 3) != 0);
                wide     = 1'($urandom_range(0, 1));
                init     = 2'($urandom_range(0, 3));
                set_init = 1'($urandom_range(0, 1));
            end
        endcase
        configure(pins, wide, init, set_init);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        for (int i = 0; i < POOL_SIZE - 1; i++)
            sel_pool[i] = SEL_W'($urandom_range(0, 127));
        // pair differing only in the top bit, to catch narrow masking
        sel_pool[POOL_SIZE - 1] = sel_pool[0] ^ 7'h40;
        if (ph == 3)
            rx_stall_req = 1'b1;
        if (ph == 5)
        begin
            run_requests(24);
            wait_idle();
            run_requests(24);
        end
        else
            run_requests(48);
    endtask

    initial
    begin
        sb = new();
        rst_n                     <= 1'b0;
        req_ch.valid              <= 1'b0;
        req_ch.requested_selector <= '0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.index              <= '0;
        cfg_ch.data               <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        run_directed();
        for (int ph = 0; ph < 8; ph++)
            run_random_phase(ph);
        wait_idle();
        if (sb.pending() > 0)
            sb.report("results never produced", 0, sb.pending());
        $display("covered %0d request items over %0d register settings", sb.requests,
                 settings_run + 1);
        $display("slot hits: %0d, slot rewrites: %0d, mismatches: %0d", sb.hits, sb.rewrites,
                 sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("status: fail");
        $finish;
    end

endmodule
